/* rtl/core/gvsp_pkg.sv */
// Package for the grid vertex sphere projection core.
// Holds the beat types, register indexes and fixed-point constants.
// No dependencies.
package gvsp_pkg;

  // Clamp limits for the patch count and the ring number.
  localparam int unsigned MAX_PATCHES = 256;
  localparam int unsigned MAX_RINGS = 8;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Y    = 3'd1,
    CFG_OFFSET_Z    = 3'd2,
    CFG_TANGENT_U   = 3'd3,
    CFG_TANGENT_V   = 3'd4,
    CFG_RADIUS      = 3'd5,
    CFG_BASE_EXTENT = 3'd6,
    CFG_PATCH_COUNT = 3'd7
  } cfg_idx_e;

  // Register reset values.
  localparam logic [47:0] TANGENT_U_RESET = 48'h0000_0000_4000;
  localparam logic [47:0] TANGENT_V_RESET = 48'h4000_0000_0000;
  localparam logic [30:0] BASE_EXTENT_RESET = 31'd16;
  localparam logic [8:0] PATCH_COUNT_RESET = 9'd64;

  // Quotient bits produced by the pipelined long dividers.
  localparam int unsigned DIV_QW = 31;
  // Newton steps of the reciprocal square root.
  localparam int unsigned NEWT_ITERS = 4;
  // ceil(2^34 / 3): exact floor division by three for operands below 2^33.
  localparam logic [32:0] RECIP3 = 33'd5726623062;

  typedef struct packed {
    logic [2:0] ring_index;
    logic [8:0] grid_row;
    logic [8:0] grid_col;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               degenerate;
  } out_beat_t;

endpackage

/* rtl/core/grid_vertex_sphere_projection_core.sv */
// Top level of the grid vertex sphere projection core: a pipeline from grid
// point to sphere position, normal and uv.
// Depends on gvsp_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------
//   in      | sink      | in_valid_i/in_ready_o | in_beat_t
//   out     | source    | out_valid_o/out_ready_i | out_beat_t
//   cfg     | sink      | cfg_we_i (no wait)    | cfg_idx_i, cfg_wdata_i
//
// One beat enters per cycle while the pipeline moves. The pipeline depth is
// set by the 31 one-bit steps of the long dividers and the four Newton steps
// of three multiplies each.
// Reset clears the stage valid bits and loads the register reset values.
// When the output beat is not taken the whole pipeline holds in place.
module grid_vertex_sphere_projection_core
  import gvsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned S_IN    = 0;
  localparam int unsigned S_NUM   = 1;
  localparam int unsigned S_DIV0  = 2;
  localparam int unsigned S_MUL   = S_DIV0 + DIV_QW;
  localparam int unsigned S_PSUM  = S_MUL + 1;
  localparam int unsigned S_ABS   = S_PSUM + 1;
  localparam int unsigned S_GRP   = S_ABS + 1;
  localparam int unsigned S_LEAD  = S_GRP + 1;
  localparam int unsigned S_NORM  = S_LEAD + 1;
  localparam int unsigned S_SQ    = S_NORM + 1;
  localparam int unsigned S_X     = S_SQ + 1;
  localparam int unsigned S_SEED1 = S_X + 1;
  localparam int unsigned S_SEED2 = S_SEED1 + 1;
  localparam int unsigned S_NEWT0 = S_SEED2 + 1;
  localparam int unsigned S_UMUL  = S_NEWT0 + 3 * NEWT_ITERS;
  localparam int unsigned S_URND  = S_UMUL + 1;
  localparam int unsigned S_PMUL  = S_URND + 1;
  localparam int unsigned S_OUT   = S_PMUL + 1;
  localparam int unsigned NS      = S_OUT + 1;

  typedef struct packed {
    logic [8:0]        n;
    logic [8:0]        row;
    logic [8:0]        col;
    logic [30:0]       ext;
    logic              sgn_x;
    logic              sgn_z;
    logic [3:0][8:0]   rem;
    logic [3:0][30:0]  nlo;
    logic [2:0][47:0]  pu;
    logic [2:0][47:0]  pv;
    logic [2:0][34:0]  p;
    logic [2:0][33:0]  pa;
    logic [2:0]        neg;
    logic [33:0]       orw;
    logic [5:0]        gnz;
    logic [5:0][2:0]   gidx;
    logic [5:0]        lead;
    logic              zero;
    logic [2:0][29:0]  qm;
    logic [2:0][59:0]  sq;
    logic [31:0]       x;
    logic              sh30;
    logic [64:0]       seedp;
    logic [31:0]       y;
    logic [31:0]       y2;
    logic [33:0]       t;
    logic [2:0][61:0]  up;
    logic [2:0][32:0]  um;
    logic [2:0][63:0]  pp;
    logic [2:0][15:0]  nrm;
    out_beat_t         res;
  } pipe_t;

  logic [2:0][31:0] cfg_off_q;
  logic [47:0]      cfg_tu_q;
  logic [47:0]      cfg_tv_q;
  logic [30:0]      cfg_rad_q;
  logic [30:0]      cfg_base_q;
  logic [8:0]       cfg_pc_q;

  logic [NS-1:0]    v_q;
  pipe_t            s_q [NS];
  pipe_t            s_d [NS];
  logic             en;

  // The pipeline moves as a whole whenever the output register is empty or its beat is taken.
  assign en          = !v_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = s_q[NS-1].res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_off_q  <= '0;
      cfg_tu_q   <= TANGENT_U_RESET;
      cfg_tv_q   <= TANGENT_V_RESET;
      cfg_rad_q  <= '0;
      cfg_base_q <= BASE_EXTENT_RESET;
      cfg_pc_q   <= PATCH_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_X:    cfg_off_q[0] <= cfg_wdata_i[31:0];
        CFG_OFFSET_Y:    cfg_off_q[1] <= cfg_wdata_i[31:0];
        CFG_OFFSET_Z:    cfg_off_q[2] <= cfg_wdata_i[31:0];
        CFG_TANGENT_U:   cfg_tu_q     <= cfg_wdata_i;
        CFG_TANGENT_V:   cfg_tv_q     <= cfg_wdata_i;
        CFG_RADIUS:      cfg_rad_q    <= cfg_wdata_i[30:0];
        CFG_BASE_EXTENT: cfg_base_q   <= cfg_wdata_i[30:0];
        CFG_PATCH_COUNT: cfg_pc_q     <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= s_d;
    end
  end

  always_comb begin : stage_logic
    logic [8:0]        n;
    logic [2:0]        ring;
    logic [39:0]       e40;
    logic signed [10:0] cx;
    logic signed [10:0] cz;
    logic [8:0]        mx;
    logic [8:0]        mz;
    logic [3:0][39:0]  num;
    logic [9:0]        den;
    logic [9:0]        trial;
    logic              qbit;
    logic signed [31:0] lx;
    logic signed [31:0] lz;
    logic signed [15:0] tc;
    logic signed [47:0] prod;
    logic [48:0]       sum;
    logic [48:0]       smag;
    logic [34:0]       rr;
    logic [34:0]       offe;
    logic [35:0]       ow;
    logic [5:0]        grp;
    logic [33:0]       sm;
    logic [61:0]       ssum;
    logic [32:0]       nsd;
    logic [63:0]       p64;
    logic [31:0]       f;
    logic [62:0]       r63;
    logic [33:0]       nm;
    logic [14:0]       nc;
    logic [64:0]       pr;
    logic [34:0]       pm;
    logic [2:0][31:0]  posv;

    s_d[0] = s_q[0];
    for (int i = 1; i < NS; i++) begin
      s_d[i] = s_q[i-1];
    end

    // Clamp the inputs and form the saturated ring extent.
    n = cfg_pc_q;
    if (n == 9'd0) begin
      n = 9'd1;
    end else if (n > 9'(MAX_PATCHES)) begin
      n = 9'(MAX_PATCHES);
    end
    ring = in_data_i.ring_index;
    if (32'(ring) > MAX_RINGS - 1) begin
      ring = 3'(MAX_RINGS - 1);
    end
    e40 = 40'(cfg_base_q) << (4'(ring) + 4'd1);
    s_d[S_IN].ext = (e40 > 40'h00_7FFF_FFFF) ? 31'h7FFF_FFFF : e40[30:0];
    s_d[S_IN].n   = n;
    s_d[S_IN].row = (in_data_i.grid_row > n) ? n : in_data_i.grid_row;
    s_d[S_IN].col = (in_data_i.grid_col > n) ? n : in_data_i.grid_col;

    // Dividends: rounded extent offsets over 2n and uv over n, by magnitude.
    cx = $signed({1'b0, s_q[S_IN].col, 1'b0}) - $signed({2'b00, s_q[S_IN].n});
    cz = $signed({1'b0, s_q[S_IN].row, 1'b0}) - $signed({2'b00, s_q[S_IN].n});
    mx = cx[10] ? 9'(-cx) : 9'(cx);
    mz = cz[10] ? 9'(-cz) : 9'(cz);
    num[0] = 40'(s_q[S_IN].ext) * 40'(mx) + 40'(s_q[S_IN].n);
    num[1] = 40'(s_q[S_IN].ext) * 40'(mz) + 40'(s_q[S_IN].n);
    num[2] = 40'({s_q[S_IN].col, 16'h0000}) + 40'(s_q[S_IN].n[8:1]);
    num[3] = 40'({s_q[S_IN].row, 16'h0000}) + 40'(s_q[S_IN].n[8:1]);
    s_d[S_NUM].sgn_x = cx[10];
    s_d[S_NUM].sgn_z = cz[10];
    for (int l = 0; l < 4; l++) begin
      s_d[S_NUM].rem[l] = num[l][39:31];
      s_d[S_NUM].nlo[l] = num[l][30:0];
    end

    // One restoring division step per stage; quotient bits shift into nlo.
    for (int k = 0; k < DIV_QW; k++) begin
      for (int l = 0; l < 4; l++) begin
        den   = (l < 2) ? {s_q[S_DIV0+k-1].n, 1'b0} : {1'b0, s_q[S_DIV0+k-1].n};
        trial = {s_q[S_DIV0+k-1].rem[l], s_q[S_DIV0+k-1].nlo[l][30]};
        qbit  = (trial >= den);
        s_d[S_DIV0+k].rem[l] = qbit ? 9'(trial - den) : trial[8:0];
        s_d[S_DIV0+k].nlo[l] = {s_q[S_DIV0+k-1].nlo[l][29:0], qbit};
      end
    end

    // Tangent plane products.
    lx = s_q[S_MUL-1].sgn_x ? -$signed({1'b0, s_q[S_MUL-1].nlo[0]})
                            : $signed({1'b0, s_q[S_MUL-1].nlo[0]});
    lz = s_q[S_MUL-1].sgn_z ? -$signed({1'b0, s_q[S_MUL-1].nlo[1]})
                            : $signed({1'b0, s_q[S_MUL-1].nlo[1]});
    for (int i = 0; i < 3; i++) begin
      tc   = $signed(cfg_tu_q[16*i +: 16]);
      prod = tc * lx;
      s_d[S_MUL].pu[i] = prod;
      tc   = $signed(cfg_tv_q[16*i +: 16]);
      prod = tc * lz;
      s_d[S_MUL].pv[i] = prod;
    end

    // Round the plane term to 1/16 m and add the plane origin.
    for (int i = 0; i < 3; i++) begin
      sum  = {s_q[S_PSUM-1].pu[i][47], s_q[S_PSUM-1].pu[i]}
           + {s_q[S_PSUM-1].pv[i][47], s_q[S_PSUM-1].pv[i]};
      smag = sum[48] ? -sum : sum;
      rr   = 35'((smag + 49'd8192) >> 14);
      offe = {{3{cfg_off_q[i][31]}}, cfg_off_q[i]};
      s_d[S_PSUM].p[i] = sum[48] ? offe - rr : offe + rr;
    end

    s_d[S_ABS].orw = '0;
    for (int i = 0; i < 3; i++) begin
      s_d[S_ABS].neg[i] = s_q[S_ABS-1].p[i][34];
      s_d[S_ABS].pa[i]  = s_q[S_ABS-1].p[i][34] ? 34'(-s_q[S_ABS-1].p[i])
                                                : s_q[S_ABS-1].p[i][33:0];
      s_d[S_ABS].orw    = s_d[S_ABS].orw | s_d[S_ABS].pa[i];
    end

    // The leading one of the OR of the magnitudes is that of the largest one.
    ow = {2'b00, s_q[S_GRP-1].orw};
    for (int g = 0; g < 6; g++) begin
      grp = ow[6*g +: 6];
      s_d[S_GRP].gnz[g]  = |grp;
      s_d[S_GRP].gidx[g] = '0;
      for (int b = 0; b < 6; b++) begin
        if (grp[b]) begin
          s_d[S_GRP].gidx[g] = 3'(b);
        end
      end
    end

    s_d[S_LEAD].zero = ~|s_q[S_LEAD-1].gnz;
    s_d[S_LEAD].lead = '0;
    for (int g = 0; g < 6; g++) begin
      if (s_q[S_LEAD-1].gnz[g]) begin
        s_d[S_LEAD].lead = 6'(6 * g) + 6'(s_q[S_LEAD-1].gidx[g]);
      end
    end

    // Bring the largest magnitude into [2^29, 2^30).
    for (int i = 0; i < 3; i++) begin
      if (s_q[S_NORM-1].lead >= 6'd30) begin
        sm = s_q[S_NORM-1].pa[i] >> (s_q[S_NORM-1].lead - 6'd29);
      end else begin
        sm = s_q[S_NORM-1].pa[i] << (6'd29 - s_q[S_NORM-1].lead);
      end
      s_d[S_NORM].qm[i] = sm[29:0];
    end

    for (int i = 0; i < 3; i++) begin
      s_d[S_SQ].sq[i] = s_q[S_SQ-1].qm[i] * s_q[S_SQ-1].qm[i];
    end

    ssum = 62'(s_q[S_X-1].sq[0]) + 62'(s_q[S_X-1].sq[1]) + 62'(s_q[S_X-1].sq[2]);
    s_d[S_X].sh30 = (ssum[61:60] != 2'b00);
    s_d[S_X].x    = s_d[S_X].sh30 ? ssum[61:30] : ssum[59:28];

    // Linear seed (7 - x) / 6 in Q30, divided by three through a reciprocal.
    nsd = 33'h1_C000_0000 - {1'b0, s_q[S_SEED1-1].x};
    s_d[S_SEED1].seedp = nsd[32:1] * RECIP3;
    s_d[S_SEED2].y = {1'b0, s_q[S_SEED2-1].seedp[64:34]};

    for (int j = 0; j < NEWT_ITERS; j++) begin
      p64 = s_q[S_NEWT0+3*j-1].y * s_q[S_NEWT0+3*j-1].y;
      s_d[S_NEWT0+3*j].y2 = p64[61:30];
      p64 = s_q[S_NEWT0+3*j].x * s_q[S_NEWT0+3*j].y2;
      s_d[S_NEWT0+3*j+1].t = p64[63:30];
      f = (s_q[S_NEWT0+3*j+1].t < 34'h0_C000_0000)
        ? 32'(34'h0_C000_0000 - s_q[S_NEWT0+3*j+1].t) : 32'd0;
      p64 = s_q[S_NEWT0+3*j+1].y * f;
      s_d[S_NEWT0+3*j+2].y = p64[62:31];
    end

    for (int i = 0; i < 3; i++) begin
      s_d[S_UMUL].up[i] = s_q[S_UMUL-1].qm[i] * s_q[S_UMUL-1].y;
    end

    for (int i = 0; i < 3; i++) begin
      r63 = {1'b0, s_q[S_URND-1].up[i]}
          + (s_q[S_URND-1].sh30 ? (63'd1 << 29) : (63'd1 << 28));
      s_d[S_URND].um[i] = s_q[S_URND-1].sh30 ? r63[62:30] : r63[61:29];
    end

    // Position products by the radius, and the rounded normal clamped to one.
    for (int i = 0; i < 3; i++) begin
      s_d[S_PMUL].pp[i] = s_q[S_PMUL-1].um[i] * cfg_rad_q;
      nm = {1'b0, s_q[S_PMUL-1].um[i]} + 34'h0_0000_8000;
      nc = (nm[33:16] > 18'd16384) ? 15'd16384 : nm[30:16];
      s_d[S_PMUL].nrm[i] = s_q[S_PMUL-1].neg[i] ? -{1'b0, nc} : {1'b0, nc};
    end

    // Round the positions to 1/16 m and saturate them to 32 bits signed.
    for (int i = 0; i < 3; i++) begin
      pr = {1'b0, s_q[S_OUT-1].pp[i]} + (65'd1 << 29);
      pm = pr[64:30];
      if (s_q[S_OUT-1].neg[i]) begin
        posv[i] = (pm > 35'h0_8000_0000) ? 32'h8000_0000 : -pm[31:0];
      end else begin
        posv[i] = (pm > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : pm[31:0];
      end
    end
    s_d[S_OUT].res.pos_x      = posv[0];
    s_d[S_OUT].res.pos_y      = posv[1];
    s_d[S_OUT].res.pos_z      = posv[2];
    s_d[S_OUT].res.normal_x   = s_q[S_OUT-1].nrm[0];
    s_d[S_OUT].res.normal_y   = s_q[S_OUT-1].nrm[1];
    s_d[S_OUT].res.normal_z   = s_q[S_OUT-1].nrm[2];
    s_d[S_OUT].res.tex_u      = s_q[S_OUT-1].nlo[2][16:0];
    s_d[S_OUT].res.tex_v      = s_q[S_OUT-1].nlo[3][16:0];
    s_d[S_OUT].res.degenerate = s_q[S_OUT-1].zero;
  end

endmodule

/* tb/tb_grid_vertex_sphere_projection_core.sv */
// Testbench for grid_vertex_sphere_projection_core: random and directed grid points
// under several register settings, checked against a predictor held in a scoreboard.
// Depends on gvsp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_grid_vertex_sphere_projection_core;
  import gvsp_pkg::*;

  class projection_scoreboard;
    logic [31:0] off_x, off_y, off_z;
    logic [47:0] tan_u, tan_v;
    logic [30:0] rad, base_ext;
    logic [8:0]  patches;
    out_beat_t   pending_q[$];
    int          mismatches;
    int          checked;
    int          degenerate_seen;

    function new();
      off_x = '0; off_y = '0; off_z = '0;
      tan_u = TANGENT_U_RESET;
      tan_v = TANGENT_V_RESET;
      rad = '0;
      base_ext = BASE_EXTENT_RESET;
      patches = PATCH_COUNT_RESET;
      mismatches = 0;
      checked = 0;
      degenerate_seen = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [47:0] val);
      case (idx)
        CFG_OFFSET_X:    off_x = val[31:0];
        CFG_OFFSET_Y:    off_y = val[31:0];
        CFG_OFFSET_Z:    off_z = val[31:0];
        CFG_TANGENT_U:   tan_u = val;
        CFG_TANGENT_V:   tan_v = val;
        CFG_RADIUS:      rad = val[30:0];
        CFG_BASE_EXTENT: base_ext = val[30:0];
        CFG_PATCH_COUNT: patches = val[8:0];
        default: ;
      endcase
    endfunction

    // Rounds v / 2^s to nearest, ties away from zero.
    function longint round_shift(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
    endfunction

    function longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function out_beat_t project_point(in_beat_t b);
      out_beat_t r;
      longint n, row, col, ext, lx, lz, m, a, tu, tv;
      longint p[3], q[3], u[3], offs[3];
      longint unsigned e64, s, x, y, y2, t, f;
      int sh, k, i;
      bit zero;
      n = patches;
      if (n < 1) n = 1;
      if (n > MAX_PATCHES) n = MAX_PATCHES;
      row = b.grid_row;
      col = b.grid_col;
      if (row > n) row = n;
      if (col > n) col = n;
      e64 = longint'(base_ext) << (b.ring_index + 1);
      ext = e64 > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : longint'(e64);
      lx = round_div(ext * (2 * col - n), 2 * n);
      lz = round_div(ext * (2 * row - n), 2 * n);
      offs[0] = longint'($signed(off_x));
      offs[1] = longint'($signed(off_y));
      offs[2] = longint'($signed(off_z));
      m = 0;
      for (i = 0; i < 3; i++) begin
        tu = longint'($signed(tan_u[16*i +: 16]));
        tv = longint'($signed(tan_v[16*i +: 16]));
        p[i] = offs[i] + round_shift(tu * lx + tv * lz, 14);
        a = p[i] < 0 ? -p[i] : p[i];
        if (a > m) m = a;
      end
      zero = (m == 0);
      for (i = 0; i < 3; i++) u[i] = 0;
      if (!zero) begin
        // Bring the largest component into [2^29, 2^30) before the square root.
        k = 0;
        while ((m >> k) >= (longint'(1) << 30)) k++;
        for (i = 0; i < 3; i++) begin
          a = (p[i] < 0 ? -p[i] : p[i]) >> k;
          q[i] = p[i] < 0 ? -a : a;
        end
        m = m >> k;
        while (m < (longint'(1) << 29)) begin
          m = m * 2;
          for (i = 0; i < 3; i++) q[i] = q[i] * 2;
        end
        s = 0;
        for (i = 0; i < 3; i++) s += longint'(q[i] * q[i]);
        if (s < (64'd1 << 60)) begin
          x = s >> 28; sh = 29;
        end else begin
          x = s >> 30; sh = 30;
        end
        y = ((64'd7 << 30) - x) / 6;
        for (k = 0; k < NEWT_ITERS; k++) begin
          y2 = (y * y) >> 30;
          t = (x * y2) >> 30;
          f = t < (64'd3 << 30) ? (64'd3 << 30) - t : 0;
          y = (y * f) >> 31;
        end
        for (i = 0; i < 3; i++) u[i] = round_shift(q[i] * longint'(y), sh);
      end
      r.pos_x = zero ? 32'd0 : 32'(clamp(round_shift(u[0] * longint'(rad), 30),
                                         -64'sd2147483648, 64'sd2147483647));
      r.pos_y = zero ? 32'd0 : 32'(clamp(round_shift(u[1] * longint'(rad), 30),
                                         -64'sd2147483648, 64'sd2147483647));
      r.pos_z = zero ? 32'd0 : 32'(clamp(round_shift(u[2] * longint'(rad), 30),
                                         -64'sd2147483648, 64'sd2147483647));
      r.normal_x = zero ? 16'd0 : 16'(clamp(round_shift(u[0], 16), -16384, 16384));
      r.normal_y = zero ? 16'd0 : 16'(clamp(round_shift(u[1], 16), -16384, 16384));
      r.normal_z = zero ? 16'd0 : 16'(clamp(round_shift(u[2], 16), -16384, 16384));
      r.tex_u = 17'((col * 65536 + n / 2) / n);
      r.tex_v = 17'((row * 65536 + n / 2) / n);
      r.degenerate = zero;
      return r;
    endfunction

    function void note_input(in_beat_t b);
      pending_q.insert(pending_q.size(), project_point(b));
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
      mismatches++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
      if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
      if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
      if (got.normal_x !== want.normal_x)
        report_mismatch("normal_x", got.normal_x, want.normal_x);
      if (got.normal_y !== want.normal_y)
        report_mismatch("normal_y", got.normal_y, want.normal_y);
      if (got.normal_z !== want.normal_z)
        report_mismatch("normal_z", got.normal_z, want.normal_z);
      if (got.tex_u !== want.tex_u) report_mismatch("tex_u", got.tex_u, want.tex_u);
      if (got.tex_v !== want.tex_v) report_mismatch("tex_v", got.tex_v, want.tex_v);
      if (got.degenerate !== want.degenerate)
        report_mismatch("degenerate", got.degenerate, want.degenerate);
      if (want.degenerate) degenerate_seen++;
      checked++;
    endtask
  endclass

  localparam int STALL_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  projection_scoreboard sb = new();
  in_beat_t point_q[$];
  int       queued = 0;
  int       accepted = 0;
  bit       in_taken = 1'b0;
  bit       calm = 1'b0;
  int       quiet_cycles = 0;
  int       phases = 0;

  always #5 clk_i = ~clk_i;

  grid_vertex_sphere_projection_core dut (.*);

  // Beats are recorded from the values present just before the edge.
  always @(posedge clk_i) begin
    in_taken = in_valid_i && in_ready_o;
    if (in_taken) begin
      sb.note_input(in_data_i);
      accepted++;
    end
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if (in_taken || (out_valid_o && out_ready_i) ||
        (accepted == queued && sb.pending_q.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved in %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    logic     nxt_valid;
    in_beat_t nxt_data;
    nxt_valid = in_valid_i && !in_taken;
    nxt_data = in_data_i;
    if (!nxt_valid && point_q.size() != 0 && rst_ni &&
        (calm || $urandom_range(99) >= 27)) begin
      nxt_data = point_q.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid_i <= nxt_valid;
    in_data_i <= nxt_data;
    out_ready_i <= calm || $urandom_range(99) >= 27;
  end

  task automatic write_reg(cfg_idx_e idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_setting(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic [47:0] tu, logic [47:0] tv, logic [30:0] rad,
                              logic [30:0] be, logic [8:0] pc);
    write_reg(CFG_OFFSET_X, 48'(ox));
    write_reg(CFG_OFFSET_Y, 48'(oy));
    write_reg(CFG_OFFSET_Z, 48'(oz));
    write_reg(CFG_TANGENT_U, tu);
    write_reg(CFG_TANGENT_V, tv);
    write_reg(CFG_RADIUS, 48'(rad));
    write_reg(CFG_BASE_EXTENT, 48'(be));
    write_reg(CFG_PATCH_COUNT, 48'(pc));
  endtask

  task automatic push_point(int ring, int row, int col);
    in_beat_t b;
    b.ring_index = 3'(ring);
    b.grid_row = 9'(row);
    b.grid_col = 9'(col);
    point_q.insert(point_q.size(), b);
    queued++;
  endtask

  // Mostly points on the grid; some rows and columns run past the edge.
  task automatic push_random_points(int count);
    int n;
    n = sb.patches == 0 ? 1 : (sb.patches > MAX_PATCHES ? MAX_PATCHES : sb.patches);
    repeat (count) begin
      if ($urandom_range(9) == 0)
        push_point($urandom_range(7), $urandom_range(511), $urandom_range(511));
      else
        push_point($urandom_range(7), $urandom_range(n), $urandom_range(n));
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (accepted != queued || sb.pending_q.size() != 0);
    phases++;
  endtask

  function automatic logic [47:0] rand_tangent();
    if ($urandom_range(1)) return 48'({$urandom(), $urandom()});
    return {16'($signed($urandom_range(32767) - 16384)),
            16'($signed($urandom_range(32767) - 16384)),
            16'($signed($urandom_range(32767) - 16384))};
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(2))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: grid center with zero offset is degenerate, corners, overrange.
    push_point(0, 32, 32);
    push_point(7, 32, 32);
    push_point(0, 0, 0);
    push_point(7, 64, 64);
    push_point(3, 0, 64);
    push_point(5, 511, 511);
    push_point(2, 256, 100);
    push_point(6, 17, 300);
    drain();

    // Largest extent saturates; largest radius saturates positions.
    load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 48'h8000_7FFF_C000,
                 48'h4000_8000_7FFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 9'd511);
    push_point(7, 0, 0);
    push_point(7, 256, 256);
    push_point(0, 128, 0);
    push_point(4, 511, 3);
    push_point(1, 0, 511);
    drain();

    // Zero tangents and offsets: every point is degenerate. Zero patch count.
    load_setting(32'h0, 32'h0, 32'h0, 48'h0, 48'h0, 31'd1000, 31'd0, 9'd0);
    push_point(0, 0, 0);
    push_point(7, 1, 1);
    push_point(2, 511, 0);
    drain();

    // Single patch, tiny offsets.
    load_setting(32'h1, 32'hFFFF_FFFF, 32'h0, 48'h0000_0000_4000,
                 48'h0000_4000_0000, 31'd1, 31'd1, 9'd1);
    push_point(0, 0, 0);
    push_point(0, 1, 1);
    push_point(7, 0, 1);
    push_point(3, 2, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      load_setting(rand_offset(), rand_offset(), rand_offset(), rand_tangent(),
                   rand_tangent(), $urandom_range(1) ? 31'($urandom()) : 31'd65536,
                   $urandom_range(3) == 0 ? 31'($urandom()) : 31'($urandom_range(4096)),
                   $urandom_range(7) == 0 ? 9'($urandom()) : 9'($urandom_range(1, 256)));
      calm = (ph == 3);
      push_random_points(80);
      drain();
    end
    calm = 1'b0;

    repeat (80) @(negedge clk_i);
    $display("Covered %0d register settings and %0d grid points, %0d of them degenerate.",
             phases, sb.checked, sb.degenerate_seen);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
